// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/htfd_pkg.sv =====
package htfd_pkg;

  localparam logic [2:0] CNT_IDLE      = 3'd0;
  localparam logic [2:0] CNT_FIRST     = 3'd1;
  localparam logic [2:0] CNT_LAST_DATA = 3'd5;
  localparam logic [2:0] CNT_CRC       = 3'd6;

  localparam logic [7:0]  CRC_POLY     = 8'h31;
  localparam logic [7:0]  CRC_INIT     = 8'hFF;
  localparam int          BUSY_BIT     = 7;
  localparam logic [13:0] HUM_SCALE    = 14'd10000;
  localparam logic [14:0] TEMP_SCALE   = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET  = 15'd5000;

  typedef struct packed {
    logic        emit;
    logic [7:0]  status;
    logic [39:0] payload;
    logic        crc_ok;
  } frame_res_t;

  typedef struct packed {
    logic               busy_res;
    logic [7:0]         status_byte;
    logic [19:0]        humidity_raw;
    logic [19:0]        temperature_raw;
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;
    logic               crc_ok;
  } out_item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/htfd_frame.sv =====
module htfd_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  input  logic                  crc_mode,
  output htfd_pkg::frame_res_t  res
);

  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  status_hold, status_hold_next;
  logic [39:0] payload_shift, payload_shift_next;
  logic [7:0]  crc_running, crc_running_next;

  always_comb begin
    byte_count_next    = byte_count;
    status_hold_next   = status_hold;
    payload_shift_next = payload_shift;
    crc_running_next   = crc_running;
    res.emit           = 1'b0;
    res.crc_ok         = 1'b1;
    priority if (frame_start) begin
      status_hold_next   = data_byte;
      payload_shift_next = '0;
      crc_running_next   = htfd_pkg::crc8_step(htfd_pkg::CRC_INIT, data_byte);
      byte_count_next    = htfd_pkg::CNT_FIRST;
    end else if (byte_count >= htfd_pkg::CNT_FIRST && byte_count <= htfd_pkg::CNT_LAST_DATA) begin
      payload_shift_next = {payload_shift[31:0], data_byte};
      crc_running_next   = htfd_pkg::crc8_step(crc_running, data_byte);
      if (byte_count == htfd_pkg::CNT_LAST_DATA) begin
        if (crc_mode) begin
          byte_count_next = htfd_pkg::CNT_CRC;
        end else begin
          byte_count_next = htfd_pkg::CNT_IDLE;
          res.emit        = 1'b1;
        end
      end else begin
        byte_count_next = byte_count + 3'd1;
      end
    end else if (byte_count == htfd_pkg::CNT_CRC) begin
      byte_count_next = htfd_pkg::CNT_IDLE;
      res.emit        = 1'b1;
      res.crc_ok      = (data_byte == crc_running);
    end else begin
      byte_count_next = htfd_pkg::CNT_IDLE;
    end
    res.status  = status_hold_next;
    res.payload = payload_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= htfd_pkg::CNT_IDLE;
      status_hold   <= '0;
      payload_shift <= '0;
      crc_running   <= htfd_pkg::CRC_INIT;
    end else if (step) begin
      byte_count    <= byte_count_next;
      status_hold   <= status_hold_next;
      payload_shift <= payload_shift_next;
      crc_running   <= crc_running_next;
    end
  end

endmodule

// ===== rtl/htfd_scale.sv =====
module htfd_scale (
  input  htfd_pkg::frame_res_t res,
  output htfd_pkg::out_item_t  item
);

  logic        busy;
  logic [19:0] hum_raw;
  logic [19:0] temp_raw;
  logic [33:0] hum_prod;
  logic [34:0] temp_prod;
  logic [14:0] temp_q;

  always_comb begin
    busy      = res.status[htfd_pkg::BUSY_BIT];
    hum_raw   = res.payload[39:20];
    temp_raw  = res.payload[19:0];
    hum_prod  = 34'(hum_raw) * 34'(htfd_pkg::HUM_SCALE);
    temp_prod = 35'(temp_raw) * 35'(htfd_pkg::TEMP_SCALE);
    temp_q    = temp_prod[34:20];

    item.busy_res    = busy;
    item.status_byte = res.status;
    item.crc_ok      = res.crc_ok;
    if (busy) begin
      item.humidity_raw      = '0;
      item.temperature_raw   = '0;
      item.humidity_centi    = '0;
      item.temperature_centi = '0;
    end else begin
      item.humidity_raw      = hum_raw;
      item.temperature_raw   = temp_raw;
      item.humidity_centi    = hum_prod[33:20];
      item.temperature_centi = $signed(temp_q - htfd_pkg::TEMP_OFFSET);
    end
  end

endmodule

// ===== rtl/humidity_temp_frame_decoder_core.sv =====
// Sensor frame decoder: takes one frame byte per item on the s_ side (tuser marks the status
// byte) and gives one result item per complete frame on the m_ side. One byte can be taken
// every cycle. A byte is held in an input register and processed, when the output register
// is free or m_tready takes its result (CRC-8 byte step, payload shift and the two scaling
// multiplies), into the output register, which presents the result of a frame's last byte.
// s_tready falls only while the input register is full and the output register holds a
// result that m_tready does not take. crc_mode is written over the cfg channel, which is
// always ready, and applies from the next frame byte processed.
`include "assert_macros.svh"

module humidity_temp_frame_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // crc_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // data_byte
  input  logic [0:0]  s_tuser,      // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // status_byte, humidity_raw, temperature_raw, humidity_centi, temperature_centi, zero pad
  output logic [79:0] m_tdata,
  output logic [1:0]  m_tuser       // busy_res, crc_ok
);

  logic                 crc_mode;
  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_start;
  logic                 go;
  logic                 step;
  logic                 out_valid;
  htfd_pkg::frame_res_t res;
  htfd_pkg::out_item_t  item;
  htfd_pkg::out_item_t  out_item;

  assign cfg_ready = 1'b1;
  assign go        = !out_valid || m_tready;
  assign step      = go && in_valid;
  assign s_tready  = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      crc_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  htfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (in_byte),
    .frame_start (in_start),
    .crc_mode    (crc_mode),
    .res         (res)
  );

  htfd_scale u_scale (
    .res  (res),
    .item (item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_item <= item;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_item.temperature_centi, out_item.humidity_centi,
                     out_item.temperature_raw, out_item.humidity_raw, out_item.status_byte};
  assign m_tuser  = {out_item.crc_ok, out_item.busy_res};

  `ASSERT_IMPL(a_stall_blocks_input, clk, rst, in_valid && out_valid && !m_tready, !s_tready)
  `ASSERT_NEXT(a_accept_fills_input, clk, rst, s_tvalid && s_tready, in_valid)
  `ASSERT_IMPL(a_busy_zero_values, clk, rst, m_tvalid && m_tuser[0], m_tdata[76:8] == 69'd0)
  `ASSERT_IMPL(a_humidity_range, clk, rst, m_tvalid, m_tdata[61:48] <= 14'd9999)

endmodule
